// File: rtl/pfw_pkg.sv
// Shared types and constants for the four-level page table walker.
// Used by pfw_ctrl, pfw_dp and four_level_page_walker_alloc; depends on nothing.
`default_nettype none

package pfw_pkg;

   localparam int KIND_W   = 2;
   localparam int VA_W     = 48;
   localparam int FLAG_W   = 12;
   localparam int STATUS_W = 3;
   localparam int PHYS_W   = 20;
   localparam int OFFS_W   = 12;
   localparam int IDX_W    = 9;
   localparam int LEVEL_W  = 2;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MAP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_MAPPED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_ALREADY    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_OOM        = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_FLAGS  = 3'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd0;

   localparam logic [FLAG_W-1:0] ENT_PRESENT = 12'h001;
   localparam logic [FLAG_W-1:0] ENT_RW      = 12'h002;
   localparam logic [FLAG_W-1:0] ENT_USER    = 12'h004;
   localparam logic [FLAG_W-1:0] TABLE_FLAGS = ENT_PRESENT | ENT_RW | ENT_USER;
   localparam logic [FLAG_W-1:0] LEAF_FLAGS  = ENT_PRESENT | ENT_USER;

   typedef struct packed {
      logic                clear_wr;
      logic                req_load;
      logic                mem_rd;
      logic [LEVEL_W-1:0]  level;
      logic                wr_table;
      logic                wr_map;
      logic                wr_or;
      logic                take_frame;
      logic                table_from_alloc;
      logic                table_from_entry;
      logic                leaf_save;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_zero;
   } cmd_type;

   typedef struct packed {
      logic              clear_last;
      logic [KIND_W-1:0] kind;
      logic              no_execute;
      logic              ent_zero;
      logic              frames_out;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/pfw_ctrl.sv
// Controller state machine for the page table walker: clearing pass, walk sequencing
// and response handshake. Depends on pfw_pkg and drives pfw_dp through cmd_type.
`default_nettype none

module pfw_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   input  wire pfw_pkg::stat_type stat,
   output pfw_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [pfw_pkg::LEVEL_W-1:0]    level_ff, level_in;
   logic [pfw_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           zero_ff, zero_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      status_in    = status_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      cmd.level      = level_ff;
      cmd.rsp_status = status_ff;
      cmd.rsp_zero   = zero_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            if (stat.kind == pfw_pkg::KIND_UNUSED) begin
               status_in = pfw_pkg::STAT_BAD_FLAGS;
               zero_in   = 1'b1;
               state_in  = S_DONE;
            end else begin
               level_in = pfw_pkg::LEVEL_TOP;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (level_ff != pfw_pkg::LEVEL_LEAF) begin
               if (stat.ent_zero && stat.frames_out) begin
                  status_in = pfw_pkg::STAT_OOM;
                  zero_in   = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  if (stat.ent_zero) begin
                     cmd.wr_table         = 1'b1;
                     cmd.take_frame       = 1'b1;
                     cmd.table_from_alloc = 1'b1;
                  end else begin
                     cmd.table_from_entry = 1'b1;
                  end
                  level_in = level_ff - 1'b1;
                  state_in = S_READ;
               end
            end else begin
               cmd.leaf_save = 1'b1;
               zero_in       = 1'b0;
               state_in      = S_DONE;
               case (stat.kind)
                  pfw_pkg::KIND_LOOKUP: begin
                     status_in = stat.ent_zero ? pfw_pkg::STAT_NOT_MAPPED : pfw_pkg::STAT_OK;
                  end
                  pfw_pkg::KIND_MAP: begin
                     if (!stat.ent_zero) begin
                        status_in = pfw_pkg::STAT_ALREADY;
                     end else if (stat.frames_out) begin
                        status_in = pfw_pkg::STAT_OOM;
                        zero_in   = 1'b1;
                     end else begin
                        cmd.wr_map     = 1'b1;
                        cmd.take_frame = 1'b1;
                        status_in      = pfw_pkg::STAT_OK;
                     end
                  end
                  pfw_pkg::KIND_ADD: begin
                     if (stat.ent_zero) begin
                        status_in = pfw_pkg::STAT_NOT_MAPPED;
                     end else if (stat.no_execute) begin
                        status_in = pfw_pkg::STAT_BAD_FLAGS;
                     end else begin
                        cmd.wr_or = 1'b1;
                        status_in = pfw_pkg::STAT_OK;
                     end
                  end
                  default: begin
                     status_in = pfw_pkg::STAT_BAD_FLAGS;
                     zero_in   = 1'b1;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         level_ff     <= pfw_pkg::LEVEL_TOP;
         status_ff    <= pfw_pkg::STAT_OK;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         status_ff    <= status_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/pfw_dp.sv
// Datapath of the page table walker: request registers, table memory, frame
// allocator and response registers. Depends on pfw_pkg; steered by pfw_ctrl.
`default_nettype none

module pfw_dp #(
   parameter int MEM_FRAMES = 256,
   parameter int ROOT_FRAME = 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pfw_pkg::cmd_type                cmd,
   output pfw_pkg::stat_type                    stat,
   input  wire logic [pfw_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [pfw_pkg::VA_W-1:0]        req_virt_addr,
   input  wire logic [pfw_pkg::FLAG_W-1:0]      req_flag_bits,
   input  wire logic                            req_no_execute,
   output logic      [pfw_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [pfw_pkg::PHYS_W-1:0]      rsp_phys_addr,
   output logic      [pfw_pkg::FLAG_W-1:0]      rsp_leaf_flags
);

   localparam int DEPTH = MEM_FRAMES * 512;
   localparam int FW    = $clog2(MEM_FRAMES);
   localparam int AW    = FW + pfw_pkg::IDX_W;
   localparam int NFW   = $clog2(MEM_FRAMES + 10);
   localparam int MW    = FW + pfw_pkg::FLAG_W + 1;
   localparam int PW    = FW + pfw_pkg::OFFS_W + pfw_pkg::PHYS_W;
   localparam int ROOT  = ROOT_FRAME % MEM_FRAMES;

   logic [MW-1:0] mem [DEPTH];

   logic [pfw_pkg::KIND_W-1:0]   kind_ff;
   logic [pfw_pkg::VA_W-1:0]     va_ff;
   logic [pfw_pkg::FLAG_W-1:0]   fl_ff;
   logic                         nx_ff;
   logic [FW-1:0]                table_ff, table_in;
   logic [MW-1:0]                rd_ff;
   logic [MW-1:0]                leaf_ff, leaf_in;
   logic [AW-1:0]                clr_ff;
   logic [NFW-1:0]               next_free_ff;
   logic [pfw_pkg::STATUS_W-1:0] status_ff;
   logic [pfw_pkg::PHYS_W-1:0]   phys_ff, phys_in;
   logic [pfw_pkg::FLAG_W-1:0]   lflags_ff, lflags_in;

   logic [pfw_pkg::IDX_W-1:0] idx;
   logic [AW-1:0]             slot;
   logic [AW-1:0]             mem_addr;
   logic                      mem_we;
   logic [MW-1:0]             mem_wdata;
   logic [FW-1:0]             free_frame;
   logic [MW-1:0]             table_ent;
   logic [MW-1:0]             map_ent;
   logic [MW-1:0]             or_ent;
   logic [PW-1:0]             phys_ext;

   always_comb begin
      case (cmd.level)
         2'd3:    idx = va_ff[47:39];
         2'd2:    idx = va_ff[38:30];
         2'd1:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign slot        = {table_ff, idx};
   assign free_frame  = next_free_ff[FW-1:0];
   assign table_ent   = {1'b0, free_frame, pfw_pkg::TABLE_FLAGS};
   assign map_ent     = {nx_ff, free_frame, fl_ff | pfw_pkg::LEAF_FLAGS};
   assign or_ent      = {rd_ff[MW-1:pfw_pkg::FLAG_W], rd_ff[pfw_pkg::FLAG_W-1:0] | fl_ff};

   assign mem_we   = cmd.clear_wr | cmd.wr_table | cmd.wr_map | cmd.wr_or;
   assign mem_addr = cmd.clear_wr ? clr_ff : slot;

   always_comb begin
      if (cmd.wr_table) begin
         mem_wdata = table_ent;
      end else if (cmd.wr_map) begin
         mem_wdata = map_ent;
      end else if (cmd.wr_or) begin
         mem_wdata = or_ent;
      end else begin
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[slot];
      end
   end

   always_comb begin
      table_in = table_ff;
      if (cmd.req_load) begin
         table_in = FW'(ROOT);
      end else if (cmd.table_from_alloc) begin
         table_in = free_frame;
      end else if (cmd.table_from_entry) begin
         table_in = rd_ff[FW+pfw_pkg::FLAG_W-1:pfw_pkg::FLAG_W];
      end
   end

   always_comb begin
      if (cmd.wr_map) begin
         leaf_in = map_ent;
      end else if (cmd.wr_or) begin
         leaf_in = or_ent;
      end else begin
         leaf_in = rd_ff;
      end
   end

   assign phys_ext = PW'({leaf_ff[FW+pfw_pkg::FLAG_W-1:pfw_pkg::FLAG_W],
                          va_ff[pfw_pkg::OFFS_W-1:0]});

   always_comb begin
      phys_in   = '0;
      lflags_in = '0;
      if (!cmd.rsp_zero) begin
         lflags_in = leaf_ff[pfw_pkg::FLAG_W-1:0];
         if (cmd.rsp_status == pfw_pkg::STAT_OK) begin
            phys_in = phys_ext[pfw_pkg::PHYS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         kind_ff <= req_kind;
         va_ff   <= req_virt_addr;
         fl_ff   <= req_flag_bits;
         nx_ff   <= req_no_execute;
      end
      table_ff <= table_in;
      if (cmd.leaf_save) begin
         leaf_ff <= leaf_in;
      end
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         phys_ff   <= phys_in;
         lflags_ff <= lflags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         next_free_ff <= NFW'(ROOT_FRAME + 1);
      end else begin
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.take_frame) begin
            next_free_ff <= next_free_ff + 1'b1;
         end
      end
   end

   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.kind       = kind_ff;
   assign stat.no_execute = nx_ff;
   assign stat.ent_zero   = (rd_ff == '0);
   assign stat.frames_out = (next_free_ff >= NFW'(MEM_FRAMES));

   assign rsp_status     = status_ff;
   assign rsp_phys_addr  = phys_ff;
   assign rsp_leaf_flags = lflags_ff;

endmodule

`default_nettype wire

// File: rtl/four_level_page_walker_alloc.sv
// Top level of the four-level page table walker with a bump frame allocator.
// Depends on pfw_pkg and instantiates pfw_ctrl and pfw_dp.
//
// Each request walks four levels of page tables held in an internal table
// memory of MEM_FRAMES frames of 512 entries, rooted at frame ROOT_FRAME, and
// gets exactly one response. Missing upper-level entries are filled with fresh
// frames from a bump allocator. After reset the block clears the table memory
// one entry per cycle and takes no request until the pass ends. A request of
// the unused kind skips the walk; any other request makes four dependent reads
// of the table memory, one per level, each followed by a check of the entry,
// and a walk that runs out of memory at an upper level ends there. A finished
// response waits in an output register; the next request is accepted once it
// has been loaded.
`default_nettype none

module four_level_page_walker_alloc #(
   parameter int MEM_FRAMES = 256,
   parameter int ROOT_FRAME = 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // virt_addr[47:0], flag_bits[59:48], no_execute[60]
   input  wire logic [1:0]  req_tuser,   // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // phys_addr[19:0], leaf_flags[31:20]
   output logic [2:0]       rsp_tuser    // status[2:0]
);

   pfw_pkg::cmd_type  cmd;
   pfw_pkg::stat_type stat;

   logic [pfw_pkg::STATUS_W-1:0] rsp_status;
   logic [pfw_pkg::PHYS_W-1:0]   rsp_phys_addr;
   logic [pfw_pkg::FLAG_W-1:0]   rsp_leaf_flags;

   pfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfw_dp #(
      .MEM_FRAMES (MEM_FRAMES),
      .ROOT_FRAME (ROOT_FRAME)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_tuser),
      .req_virt_addr  (req_tdata[47:0]),
      .req_flag_bits  (req_tdata[59:48]),
      .req_no_execute (req_tdata[60]),
      .rsp_status     (rsp_status),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_leaf_flags (rsp_leaf_flags)
   );

   assign rsp_tdata = {rsp_leaf_flags, rsp_phys_addr};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

// File: tb/sv/pfw_checker.sv
`timescale 1ns / 100ps
// Response checker for the four-level page table walker: it watches both streams, predicts
// each response from its own copy of the page tables and frame allocator, and compares.
// Depends on pfw_pkg.
module pfw_checker #(
   parameter int MEM_FRAMES = 256,
   parameter int ROOT_FRAME = 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   output int               fail_count,
   output int               pending,
   output int               checked_count,
   output int               map_count,
   output int               oom_count
);

   localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;

   typedef struct packed {
      logic [pfw_pkg::STATUS_W-1:0] status;
      logic [pfw_pkg::PHYS_W-1:0]   phys;
      logic [pfw_pkg::FLAG_W-1:0]   lflags;
   } walk_result_type;

   bit [63:0]       page_words [MEM_FRAMES*512];
   int              next_frame;
   walk_result_type expected_q [$];

   function automatic int word_index(input logic [63:0] frame,
                                     input logic [pfw_pkg::IDX_W-1:0] idx);
      return int'(frame % MEM_FRAMES) * 512 + int'(idx);
   endfunction

   // Walks the tables from the root, filling missing upper levels, then acts on the leaf.
   function automatic walk_result_type page_walk(input logic [pfw_pkg::KIND_W-1:0] kind,
                                                 input logic [pfw_pkg::VA_W-1:0] va,
                                                 input logic [pfw_pkg::FLAG_W-1:0] fl,
                                                 input logic nx);
      walk_result_type r;
      logic [63:0]     table_frame;
      logic [63:0]     ent;
      int              slot;
      int              lvl;
      r = '0;
      r.status = pfw_pkg::STAT_OK;
      if (kind == pfw_pkg::KIND_UNUSED) begin
         r.status = pfw_pkg::STAT_BAD_FLAGS;
         return r;
      end
      table_frame = 64'(ROOT_FRAME);
      for (lvl = 3; lvl >= 1; lvl--) begin
         slot = word_index(table_frame, va[12 + 9*lvl +: 9]);
         if (page_words[slot] == 64'd0) begin
            if (next_frame >= MEM_FRAMES) begin
               r.status = pfw_pkg::STAT_OOM;
               return r;
            end
            page_words[slot] = (64'(next_frame) << 12) | 64'(pfw_pkg::TABLE_FLAGS);
            next_frame++;
         end
         table_frame = (page_words[slot] & ADDR_MASK) >> 12;
      end
      slot = word_index(table_frame, va[20:12]);
      ent = page_words[slot];
      case (kind)
         pfw_pkg::KIND_LOOKUP: begin
            if (ent == 64'd0) r.status = pfw_pkg::STAT_NOT_MAPPED;
         end
         pfw_pkg::KIND_MAP: begin
            if (ent != 64'd0) begin
               r.status = pfw_pkg::STAT_ALREADY;
            end else if (next_frame >= MEM_FRAMES) begin
               r.status = pfw_pkg::STAT_OOM;
            end else begin
               ent = (64'(next_frame) << 12) | 64'(fl) | 64'(pfw_pkg::LEAF_FLAGS);
               ent[63] = nx;
               page_words[slot] = ent;
               next_frame++;
            end
         end
         default: begin
            if (ent == 64'd0) begin
               r.status = pfw_pkg::STAT_NOT_MAPPED;
            end else if (nx) begin
               r.status = pfw_pkg::STAT_BAD_FLAGS;
            end else begin
               ent = ent | 64'(fl);
               page_words[slot] = ent;
            end
         end
      endcase
      if (r.status == pfw_pkg::STAT_OK) begin
         r.phys = pfw_pkg::PHYS_W'((ent & ADDR_MASK) + 64'(va[11:0]));
      end
      if (r.status != pfw_pkg::STAT_OOM) r.lflags = ent[11:0];
      return r;
   endfunction

   always @(posedge clock) begin
      walk_result_type want;
      walk_result_type got;
      int              errs;
      errs = 0;
      if (reset) begin
         foreach (page_words[w]) page_words[w] = '0;
         next_frame = ROOT_FRAME + 1;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
         checked_count <= 0;
         map_count <= 0;
         oom_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = page_walk(req_tuser, req_tdata[47:0], req_tdata[59:48], req_tdata[60]);
            expected_q.push_back(want);
            if (req_tuser == pfw_pkg::KIND_MAP && want.status == pfw_pkg::STAT_OK) begin
               map_count <= map_count + 1;
            end
            if (want.status == pfw_pkg::STAT_OOM) oom_count <= oom_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.phys = rsp_tdata[19:0];
            got.lflags = rsp_tdata[31:20];
            checked_count <= checked_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: response with no request pending: status %0d phys %h flags %h",
                        $time, got.status, got.phys, got.lflags);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, got.status);
                  errs++;
               end
               if (got.phys != want.phys) begin
                  $display("%0t: phys_addr mismatch: expected %h, got %h",
                           $time, want.phys, got.phys);
                  errs++;
               end
               if (got.lflags != want.lflags) begin
                  $display("%0t: leaf_flags mismatch: expected %h, got %h",
                           $time, want.lflags, got.lflags);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= expected_q.size();
      end
   end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the page table walker testbench: clock, reset, request stimulus and the verdict.
// Depends on pfw_pkg, four_level_page_walker_alloc and pfw_checker.
module testbench;

   localparam int MEM_FRAMES  = 256;
   localparam int ROOT_FRAME  = 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_ITEMS  = 330;
   localparam int FILL_ITEMS  = 120;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int   fail_count;
   int   pending;
   int   checked_count;
   int   map_count;
   int   oom_count;
   int   sent_count;
   int   cycle_count;
   int   rsp_hold;
   int   rsp_roll;
   logic quiet_phase;

   logic [26:0] region [4];

   always #5 clock = ~clock;

   four_level_page_walker_alloc #(
      .MEM_FRAMES(MEM_FRAMES),
      .ROOT_FRAME(ROOT_FRAME)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   pfw_checker #(
      .MEM_FRAMES(MEM_FRAMES),
      .ROOT_FRAME(ROOT_FRAME)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked_count(checked_count),
      .map_count    (map_count),
      .oom_count    (oom_count)
   );

   // The response side stalls now and then, mostly briefly and sometimes for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (quiet_phase) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 4) begin
            rsp_tready <= 1'b0;
            rsp_hold <= $urandom_range(8, 40);
         end else if (rsp_roll < 30) begin
            rsp_tready <= 1'b0;
            rsp_hold <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send(input logic [pfw_pkg::KIND_W-1:0] kind,
                       input logic [pfw_pkg::VA_W-1:0] va,
                       input logic [pfw_pkg::FLAG_W-1:0] fl, input logic nx);
      int roll;
      roll = $urandom_range(0, 99);
      if (!quiet_phase && roll < 25) begin
         req_tvalid <= 1'b0;
         repeat ((roll < 3) ? $urandom_range(10, 30) : $urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, nx, fl, va};
      req_tuser <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // The first edge lets the checker count the request that was just accepted.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [pfw_pkg::VA_W-1:0] pool_addr();
      return {region[$urandom_range(0, 3)], 5'd0, 4'($urandom_range(0, 15)), 12'($urandom)};
   endfunction

   function automatic logic [pfw_pkg::KIND_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return pfw_pkg::KIND_LOOKUP;
      if (roll < 70) return pfw_pkg::KIND_MAP;
      if (roll < 95) return pfw_pkg::KIND_ADD;
      return pfw_pkg::KIND_UNUSED;
   endfunction

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int                             i;
      int                             roll;
      logic [pfw_pkg::KIND_W-1:0]     kind;
      logic [pfw_pkg::VA_W-1:0]       va;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      quiet_phase <= 1'b0;
      sent_count = 0;
      region[0] = '0;
      for (i = 1; i < 4; i++) region[i] = 27'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty leaf, map, remap, offsets, flag merging, bad no-execute and the unused kind.
      send(pfw_pkg::KIND_LOOKUP, 48'h0000_0000_0000, 12'h000, 1'b0);
      send(pfw_pkg::KIND_ADD,    48'h0000_0000_0000, 12'h0F0, 1'b0);
      send(pfw_pkg::KIND_MAP,    48'h0000_0000_0000, 12'h000, 1'b0);
      send(pfw_pkg::KIND_MAP,    48'h0000_0000_0FFF, 12'hFFF, 1'b1);
      send(pfw_pkg::KIND_LOOKUP, 48'h0000_0000_0FFF, 12'h000, 1'b0);
      send(pfw_pkg::KIND_ADD,    48'h0000_0000_0123, 12'hFFF, 1'b0);
      send(pfw_pkg::KIND_ADD,    48'h0000_0000_0000, 12'h010, 1'b1);
      send(pfw_pkg::KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1);
      send(pfw_pkg::KIND_UNUSED, 48'h0000_0000_0000, 12'h000, 1'b0);
      send(pfw_pkg::KIND_MAP,    48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1);
      send(pfw_pkg::KIND_LOOKUP, 48'hFFFF_FFFF_F000, 12'h000, 1'b0);
      send(pfw_pkg::KIND_ADD,    48'hFFFF_FFFF_FFFF, 12'h000, 1'b0);
      send(pfw_pkg::KIND_MAP,    48'h0000_0000_1000, 12'h000, 1'b1);
      send(pfw_pkg::KIND_MAP,    48'hAAAA_AAAA_AAAA, 12'hAAA, 1'b0);
      send(pfw_pkg::KIND_MAP,    48'h5555_5555_5555, 12'h555, 1'b1);
      send(pfw_pkg::KIND_LOOKUP, 48'hAAAA_AAAA_AAAA, 12'h000, 1'b0);
      send(pfw_pkg::KIND_ADD,    48'h5555_5555_5555, 12'hAAA, 1'b0);
      send(pfw_pkg::KIND_LOOKUP, 48'h5555_5555_5555, 12'h000, 1'b0);
      send(pfw_pkg::KIND_LOOKUP, 48'h0000_0020_0000, 12'h000, 1'b0);
      send(pfw_pkg::KIND_ADD,    48'h0000_4000_0000, 12'h001, 1'b0);
      drain();

      // Most requests reuse a few table regions so that lookups and flag updates hit mapped pages.
      for (i = 0; i < POOL_ITEMS; i++) begin
         if (i == 120) quiet_phase <= 1'b1;
         if (i == 160) quiet_phase <= 1'b0;
         if (i == 200) drain();
         roll = $urandom_range(0, 99);
         va = (roll < 90) ? pool_addr() : 48'({$urandom, $urandom});
         kind = pick_kind();
         roll = $urandom_range(0, 99);
         send(kind, va, 12'($urandom),
              (kind == pfw_pkg::KIND_ADD) ? (roll < 20) : 1'($urandom));
      end

      // Maps at scattered addresses use up the frame store, so the walk runs out of memory.
      for (i = 0; i < FILL_ITEMS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            send(pfw_pkg::KIND_MAP, 48'({$urandom, $urandom}), 12'($urandom), 1'($urandom));
         end else begin
            kind = pick_kind();
            send(kind, pool_addr(), 12'($urandom), 1'($urandom));
         end
      end
      drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d requests and %0d responses: %0d pages mapped, %0d out of memory.",
               sent_count, checked_count, map_count, oom_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/pfw_pkg.sv
rtl/pfw_ctrl.sv
rtl/pfw_dp.sv
rtl/four_level_page_walker_alloc.sv
tb/sv/pfw_checker.sv
tb/sv/testbench.sv
